[design/atp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atp_pkg
// Shared widths, state codes and tag types for the autoscaled trace plotter.
// ----------------------------------------------------------------------------
package atp_pkg;

	localparam int WIN_DEPTH  = 64;
	localparam int IDX_W      = $clog2(WIN_DEPTH);
	localparam int FILL_W     = IDX_W + 1;
	localparam int SAMPLE_W   = 24;
	localparam int SPAN_W     = 24;
	localparam int ROW_W      = 10;
	localparam int HEIGHT_W   = 11;
	localparam int NUM_W      = SPAN_W + ROW_W;
	localparam int DIV_STAGES = ROW_W;
	localparam int TDATA_W    = 32;

	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(240);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(1024);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SPAN,
		ST_DRAW
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] col;
	} row_tag_t;

endpackage : atp_pkg
`default_nettype wire

[design/atp_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// atp_div
// Pipelined restoring divider, one quotient bit per stage, stalled by en.
// The quotient is known to fit ROW_W bits (numerator < 2^ROW_W * span).
// ----------------------------------------------------------------------------
module atp_div import atp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire row_tag_t          in_tag,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [SPAN_W-1:0] span,
	output row_tag_t               out_tag,
	output logic [ROW_W-1:0]       out_quot,
	output logic                   busy
);

	logic [NUM_W-1:0]  w_q   [DIV_STAGES];
	row_tag_t          tag_q [DIV_STAGES];
	logic [NUM_W-1:0]  w_nxt [DIV_STAGES];
	logic [DIV_STAGES-1:0] vld;

	genvar i;
	generate
		for (i = 0; i < DIV_STAGES; i++) begin : g_stage
			logic [NUM_W-1:0]  src;
			row_tag_t          src_tag;
			logic [SPAN_W:0]   trial;
			logic [SPAN_W:0]   diff;
			logic              ge;

			if (i == 0) begin : g_first
				assign src     = in_num;
				assign src_tag = in_tag;
			end else begin : g_next
				assign src     = w_q[i-1];
				assign src_tag = tag_q[i-1];
			end

			always_comb begin
				trial    = src[NUM_W-1:ROW_W-1];
				diff     = trial - {1'b0, span};
				ge       = (trial >= {1'b0, span});
				w_nxt[i] = ge ? {diff[SPAN_W-1:0], src[ROW_W-2:0], 1'b1}
				              : {trial[SPAN_W-1:0], src[ROW_W-2:0], 1'b0};
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					tag_q[i] <= '0;
				end else if (en) begin
					tag_q[i] <= src_tag;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					w_q[i] <= w_nxt[i];
				end
			end

			assign vld[i] = tag_q[i].valid;
		end
	endgenerate

	assign out_tag  = tag_q[DIV_STAGES-1];
	assign out_quot = w_q[DIV_STAGES-1][ROW_W-1:0];
	assign busy     = |vld;

endmodule : atp_div
`default_nettype wire

[design/autoscaled_trace_plotter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// autoscaled_trace_plotter
// Strip chart of the last 64 samples, scaled to the plot height.
// ----------------------------------------------------------------------------
// Slave stream: one 24-bit signed sample per word on s_tdata.
// Master stream: one line segment per word; m_tdata holds column, start row
// and end row, m_tlast marks the last segment drawn for a sample.
// cfg_wr_en/cfg_wr_data write the plot height; write it while idle only.
// Each sample is written into a 64-entry circular window RAM. One pass reads
// the n held samples one per cycle to find minimum and maximum, a second pass
// reads them again and feeds a 10-stage pipelined divider that yields one
// row per cycle while the receiver keeps up. Both passes use the single RAM
// read port, one after the other. s_tready is high only between samples.
// The first sample yields no segment.
// When the receiver stalls, the draw pipeline, divider and RAM read register
// hold; nothing is dropped. Reset empties the window and sets the height
// to 240; the RAM contents are not cleared, a fill count guards them.
// ----------------------------------------------------------------------------
module autoscaled_trace_plotter import atp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,   // [23:0] sample_milli
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [TDATA_W-1:0]       m_tdata,   // [5:0] seg_column, [15:6] row_start,
	                                            // [25:16] row_end, zero above
	output logic                     m_tlast,   // last_segment
	input  wire logic                cfg_wr_en,
	input  wire logic [HEIGHT_W-1:0] cfg_wr_data
);

	logic signed [SAMPLE_W-1:0] mem [WIN_DEPTH];

	state_t                     state_q, state_nxt;
	logic [HEIGHT_W-1:0]        height_q;
	logic [FILL_W-1:0]          fill_q;
	logic [IDX_W-1:0]           oldest_q;
	logic [FILL_W-1:0]          cnt_q;
	logic signed [SAMPLE_W-1:0] lo_q, hi_q;
	logic [SPAN_W-1:0]          span_q;
	logic [ROW_W-1:0]           top_q;
	logic signed [SAMPLE_W-1:0] rd_s1;
	row_tag_t                   tag_s1, tag_s2, tag_s3;
	logic [SPAN_W-1:0]          diff_s2;
	logic [NUM_W-1:0]           prod_s3;
	row_tag_t                   div_tag;
	logic [ROW_W-1:0]           div_quot;
	logic                       div_busy;
	logic [ROW_W-1:0]           prev_row_q;
	logic                       m_tvalid_q;
	logic [IDX_W-1:0]           col_q;
	logic [ROW_W-1:0]           row_start_q, row_end_q;
	logic                       last_q;

	logic                       adv, s_accept, issue, reading;
	logic [IDX_W-1:0]           wr_slot, rd_addr;
	logic [SAMPLE_W:0]          diff_full;
	logic [ROW_W-1:0]           row_now, top_nxt;
	logic [FILL_W-1:0]          fill_m1;
	logic                       pipe_empty;

	assign adv        = !m_tvalid_q || m_tready;
	assign s_accept   = s_tvalid && s_tready;
	assign issue      = reading && (cnt_q < fill_q) && adv;
	assign wr_slot    = (fill_q < FILL_W'(WIN_DEPTH)) ? oldest_q + fill_q[IDX_W-1:0] : oldest_q;
	assign rd_addr    = oldest_q + cnt_q[IDX_W-1:0];
	assign diff_full  = {rd_s1[SAMPLE_W-1], rd_s1} - {lo_q[SAMPLE_W-1], lo_q};
	assign row_now    = top_q - div_quot;
	assign fill_m1    = fill_q - FILL_W'(1);
	assign pipe_empty = !tag_s1.valid && !tag_s2.valid && !tag_s3.valid && !div_busy;

	always_comb begin
		if (height_q == '0) begin
			top_nxt = '0;
		end else if (height_q > HEIGHT_MAX) begin
			top_nxt = ROW_W'(HEIGHT_MAX - HEIGHT_W'(1));
		end else begin
			top_nxt = ROW_W'(height_q - HEIGHT_W'(1));
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (cnt_q == fill_q && !tag_s1.valid) state_nxt = ST_SPAN;
			end
			ST_SPAN: begin
				state_nxt = ST_DRAW;
			end
			ST_DRAW: begin
				if (cnt_q == fill_q && pipe_empty && !m_tvalid_q) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		reading  = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_SCAN: reading  = 1'b1;
			ST_SPAN: ;
			ST_DRAW: reading  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			height_q <= HEIGHT_RESET;
			fill_q   <= '0;
			oldest_q <= '0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) height_q <= cfg_wr_data;
			if (s_accept) begin
				cnt_q <= '0;
				if (fill_q < FILL_W'(WIN_DEPTH)) begin
					fill_q <= fill_q + FILL_W'(1);
				end else begin
					oldest_q <= oldest_q + IDX_W'(1);
				end
			end else if (state_q == ST_SPAN) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) mem[wr_slot] <= s_tdata;
		if (adv) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1     <= '0;
			tag_s2     <= '0;
			tag_s3     <= '0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			tag_s1.valid <= issue;
			tag_s1.col   <= cnt_q[IDX_W-1:0];
			tag_s2.valid <= tag_s1.valid && (state_q == ST_DRAW);
			tag_s2.col   <= tag_s1.col;
			tag_s3       <= tag_s2;
			m_tvalid_q   <= div_tag.valid && (div_tag.col != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && tag_s1.valid) begin
			if (tag_s1.col == '0) begin
				lo_q <= rd_s1;
				hi_q <= rd_s1;
			end else begin
				if (rd_s1 < lo_q) lo_q <= rd_s1;
				if (rd_s1 > hi_q) hi_q <= rd_s1;
			end
		end
		if (state_q == ST_SPAN) begin
			span_q <= (hi_q == lo_q) ? SPAN_W'(1) : SPAN_W'(hi_q - lo_q);
			top_q  <= top_nxt;
		end
		if (adv) begin
			diff_s2    <= diff_full[SPAN_W-1:0];
			prod_s3    <= NUM_W'({{ROW_W{1'b0}}, diff_s2} * {{SPAN_W{1'b0}}, top_q});
			if (div_tag.valid) begin
				prev_row_q  <= row_now;
				col_q       <= div_tag.col;
				row_start_q <= prev_row_q;
				row_end_q   <= row_now;
				last_q      <= (div_tag.col == fill_m1[IDX_W-1:0]);
			end
		end
	end

	atp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_tag   (tag_s3),
		.in_num   (prod_s3),
		.span     (span_q),
		.out_tag  (div_tag),
		.out_quot (div_quot),
		.busy     (div_busy)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(TDATA_W - IDX_W - 2*ROW_W){1'b0}}, row_end_q, row_start_q, col_q};
	assign m_tlast  = last_q;

	a_idle_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !m_tvalid_q)
		else $error("output word pending while idle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_DEPTH))
		else $error("fill count beyond window depth");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (span_q != '0))
		else $error("zero divisor during draw");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (row_end_q <= top_q && row_start_q <= top_q))
		else $error("row beyond plot height");

	a_output_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (col_q != '0 && {1'b0, col_q} < fill_q))
		else $error("segment column outside held samples");

endmodule : autoscaled_trace_plotter
`default_nettype wire

[tb/tb_autoscaled_trace_plotter.sv]
// ----------------------------------------------------------------------------
// tb_autoscaled_trace_plotter
// Streams samples into the strip chart plotter and checks every segment word
// against an in-bench model of the sliding window and its autoscaled rows, or
// against table rows. A short table covers reset, sample and height extremes
// and a flat window; random runs of wide, narrow, flat and wandering samples
// follow, each under a fresh plot height, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_autoscaled_trace_plotter import atp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEMS      = 430;
	localparam int QUIET_FROM = 380;
	localparam int SETTLE     = 200;
	localparam int HOLDOFF    = 400;
	localparam int PLAN_LEN   = 20;

	typedef enum bit {DO_SAMPLE, DO_HEIGHT} act_t;
	typedef enum int {RUN_WIDE, RUN_NARROW, RUN_FLAT, RUN_WALK} run_t;

	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [ROW_W-1:0] r0;
		logic [ROW_W-1:0] r1;
		logic             last;
	} seg_t;

	typedef struct packed {
		act_t                   act;
		logic [HEIGHT_W-1:0]    hgt;
		logic [SAMPLE_W-1:0]    smp;
		bit                     typed;
		logic [2:0]             n;
		logic [0:3][ROW_W-1:0]  rows;
	} step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tlast;
	logic                cfg_wr_en = 1'b0;
	logic [HEIGHT_W-1:0] cfg_wr_data = '0;

	logic signed [SAMPLE_W-1:0] trace [WIN_DEPTH];
	int unsigned                n_held = 0;
	int unsigned                first_slot = 0;
	logic [HEIGHT_W-1:0]        height_now = HEIGHT_RESET;

	seg_t segs_due [$];
	int   samples_sent = 0;
	int   segs_seen = 0;
	int   mismatches = 0;
	bit   quiet = 1'b0;

	step_t plan [PLAN_LEN] = '{
		'{DO_SAMPLE, 11'd0,    24'h000000, 1'b1, 3'd0, {10'd0,   10'd0,   10'd0, 10'd0}},
		'{DO_SAMPLE, 11'd0,    24'h000000, 1'b1, 3'd1, {10'd239, 10'd239, 10'd0, 10'd0}},
		'{DO_SAMPLE, 11'd0,    24'h7FFFFF, 1'b1, 3'd2, {10'd239, 10'd239, 10'd0, 10'd0}},
		'{DO_SAMPLE, 11'd0,    24'h800000, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'hFFFFFF, 1'b0, 3'd0, 40'd0},
		'{DO_HEIGHT, 11'd1,    24'h000000, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h555555, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'hAAAAAA, 1'b0, 3'd0, 40'd0},
		'{DO_HEIGHT, 11'd1024, 24'h000000, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h000001, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h7FFFFF, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h800000, 1'b0, 3'd0, 40'd0},
		'{DO_HEIGHT, 11'd0,    24'h000000, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h123456, 1'b0, 3'd0, 40'd0},
		'{DO_HEIGHT, 11'd2047, 24'h000000, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'hEDCBA9, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h7FFFFF, 1'b0, 3'd0, 40'd0},
		'{DO_HEIGHT, 11'd1025, 24'h000000, 1'b0, 3'd0, 40'd0},
		'{DO_SAMPLE, 11'd0,    24'h800000, 1'b0, 3'd0, 40'd0},
		'{DO_HEIGHT, 11'd240,  24'h000000, 1'b0, 3'd0, 40'd0}
	};

	autoscaled_trace_plotter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	function automatic logic [ROW_W-1:0] row_for(longint s, longint lo, longint span,
	                                             longint top);
		longint r;
		r = ((s - lo) * (0 - top)) / span + top;
		if (r < 0) r = 0;
		if (r > top) r = top;
		return ROW_W'(r);
	endfunction

	// Slide the window by one sample and, if keep is set, queue the segments it redraws.
	task automatic plot_sample(input logic signed [SAMPLE_W-1:0] s, input bit keep);
		longint lo, hi, span, top, v, prev;
		int     h;
		seg_t   sg;
		h = (height_now == '0) ? 1 :
		    (height_now > HEIGHT_MAX) ? int'(HEIGHT_MAX) : int'(height_now);
		top = h - 1;
		if (n_held < WIN_DEPTH) begin
			trace[(first_slot + n_held) % WIN_DEPTH] = s;
			n_held++;
		end else begin
			trace[first_slot] = s;
			first_slot = (first_slot + 1) % WIN_DEPTH;
		end
		lo = longint'(trace[first_slot]);
		hi = lo;
		for (int k = 1; k < n_held; k++) begin
			v = longint'(trace[(first_slot + k) % WIN_DEPTH]);
			if (v < lo) lo = v;
			if (v > hi) hi = v;
		end
		span = (hi == lo) ? 1 : hi - lo;
		for (int k = 1; k < n_held; k++) begin
			prev = longint'(trace[(first_slot + k - 1) % WIN_DEPTH]);
			v = longint'(trace[(first_slot + k) % WIN_DEPTH]);
			sg.col = IDX_W'(k);
			sg.r0 = row_for(prev, lo, span, top);
			sg.r1 = row_for(v, lo, span, top);
			sg.last = (k + 1 == n_held);
			if (keep) segs_due.push_back(sg);
		end
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input int idle_pct);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= s;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		quiet = (samples_sent >= QUIET_FROM);
	endtask

	// Drop valid, wait out every pending segment, then let the block go idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (segs_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_height(input logic [HEIGHT_W-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		height_now = v;
	endtask

	task automatic note_field(input string name, input int unsigned expv,
	                          input int unsigned actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d",
			         $time, name, expv, actv);
			mismatches++;
		end
	endtask

	task automatic check_segment(input logic [TDATA_W-1:0] w, input logic l);
		seg_t e;
		if (segs_due.size() == 0) begin
			$display("%0t: unexpected word, expected none, actual %h last %b",
			         $time, w, l);
			mismatches++;
			return;
		end
		e = segs_due.pop_front();
		note_field("seg_column", e.col, w[IDX_W-1:0]);
		note_field("row_start", e.r0, w[IDX_W +: ROW_W]);
		note_field("row_end", e.r1, w[IDX_W+ROW_W +: ROW_W]);
		note_field("last_segment", e.last, l);
	endtask

	initial begin : segment_sink
		int gap;
		int pct;
		gap = 0;
		pct = 25;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				check_segment(m_tdata, m_tlast);
				segs_seen++;
				if (segs_seen % 1000 == 0) pct = $urandom_range(0, 2) * 25;
				if (!quiet && (segs_seen == 1500 || segs_seen == 9000)) gap = HOLDOFF;
			end
			if (gap > 0) begin
				gap--;
				m_tready <= 1'b0;
			end else if (!quiet && arst_n && $urandom_range(0, 99) < pct) begin
				gap = $urandom_range(0, 4);
				m_tready <= 1'b0;
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	initial begin : sample_source
		seg_t  sg;
		run_t  kind;
		int    len;
		int    idle_pct;
		int    lvl;
		int    pick;
		int    phase;
		logic [HEIGHT_W-1:0] hv;
		logic [SAMPLE_W-1:0] s;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].act == DO_HEIGHT) begin
				set_height(plan[i].hgt);
			end else begin
				send_sample(plan[i].smp, 20);
				plot_sample(plan[i].smp, !plan[i].typed);
				if (plan[i].typed) begin
					for (int k = 1; k <= plan[i].n; k++) begin
						sg.col = IDX_W'(k);
						sg.r0 = plan[i].rows[k-1];
						sg.r1 = plan[i].rows[k];
						sg.last = (k == plan[i].n);
						segs_due.push_back(sg);
					end
				end
			end
		end

		phase = 0;
		while (samples_sent < ITEMS) begin
			pick = $urandom_range(0, 7);
			if (pick == 0)
				hv = $urandom_range(0, 1) ? HEIGHT_W'(0) : HEIGHT_W'($urandom_range(1025, 2047));
			else if (pick == 1)
				hv = $urandom_range(0, 1) ? HEIGHT_W'(1) : HEIGHT_MAX;
			else
				hv = HEIGHT_W'($urandom_range(1, 1024));
			set_height(hv);

			kind = run_t'($urandom_range(0, 3));
			if (phase == 2) kind = RUN_FLAT;
			else if (kind == RUN_FLAT) kind = RUN_WIDE;
			len = (kind == RUN_FLAT) ? WIN_DEPTH + 6 : $urandom_range(25, 60);
			idle_pct = $urandom_range(0, 2) * 25;
			lvl = int'($urandom());

			for (int i = 0; i < len && samples_sent < ITEMS; i++) begin
				case (kind)
					RUN_WIDE:   s = SAMPLE_W'($urandom());
					RUN_NARROW: s = SAMPLE_W'(lvl + $urandom_range(0, 80) - 40);
					RUN_FLAT:   s = SAMPLE_W'(lvl);
					default: begin
						lvl = lvl + $urandom_range(0, 2000) - 1000;
						s = SAMPLE_W'(lvl);
					end
				endcase
				send_sample(s, idle_pct);
				plot_sample(s, 1'b1);
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("tb_autoscaled_trace_plotter: clean");
		else
			$display("tb_autoscaled_trace_plotter: errors");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("tb_autoscaled_trace_plotter: errors");
		$finish;
	end

endmodule
